// ===== hw/rtl/dfr_pkg.sv =====
// shared types and constants of the checksummed packet deframer
`default_nettype none

package dfr_pkg;

  // framing phases
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_META    = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHK_LO  = 3'd5,
    PH_CHK_HI  = 3'd6
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_GOOD = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  // checksum is the inverted running sum
  localparam logic [15:0] CHECK_INVERT = 16'hFFFF;

  // register file
  localparam int          APB_ADDR_W     = 3;
  localparam logic        REG_START_BYTE = 1'b0;

  // one result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  meta_byte;
    logic [15:0] packet_length;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dfr_if.sv =====
// valid/ready channel interfaces for link bytes and results
`default_nettype none

interface dfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfr_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [7:0]  meta_byte;
  logic [15:0] packet_length;
  logic        last;

  modport source (output valid, output kind, output payload_byte, output meta_byte,
                  output packet_length, output last, input ready);
  modport sink   (input valid, input kind, input payload_byte, input meta_byte,
                  input packet_length, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/checksummed_packet_deframer_unit.sv =====
// Checksummed packet deframer, top level.
//
// link: valid/ready channel of received link bytes, one word per byte.
// result: valid/ready channel of result words. A payload byte gives a word
//   with kind data; the checksum high byte gives one word with last set and
//   kind good or bad. Start, metadata, length and checksum low bytes give none.
// APB: one register, start_byte at byte address 0, written and read back.
// Output: a result word appears on result in the cycle after its byte is taken.
// Throughput: one link byte per cycle while result is not stalled; the framing
//   state, down counter and 16-bit sum update in the cycle the byte is taken, and
//   a single output register holds the result.
// Stall: while result is stalled with a word held, link.ready drops; it rises
//   again in the cycle the held word is taken, so no bubble is inserted.
// Reset (rst, synchronous): the parser goes back to hunting for the start
//   byte, all header state and start_byte clear, and the output is empty.
`default_nettype none

module checksummed_packet_deframer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dfr_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  dfr_byte_if.sink                            link,
  dfr_result_if.source                        result
);

  logic          take;
  logic          space;
  logic          res_valid;
  logic [7:0]    start_byte;
  dfr_pkg::res_t res_word;
  dfr_pkg::res_t res_held;

  // configuration registers
  dfr_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .start_byte (start_byte)
  );

  // input handshake
  assign link.ready = space;
  assign take       = link.valid && space;

  dfr_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .start_byte (start_byte),
    .take       (take),
    .rx_byte    (link.rx_byte),
    .res_valid  (res_valid),
    .res        (res_word)
  );

  dfr_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (take && res_valid),
    .res_in    (res_word),
    .space     (space),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .res_out   (res_held)
  );

  // result payload
  assign result.kind          = res_held.kind;
  assign result.payload_byte  = res_held.payload_byte;
  assign result.meta_byte     = res_held.meta_byte;
  assign result.packet_length = res_held.packet_length;
  assign result.last          = res_held.last;

endmodule

`default_nettype wire

// ===== hw/rtl/dfr_cfg.sv =====
// apb register block holding the start byte
`default_nettype none

module dfr_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dfr_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output logic [7:0]                          start_byte
);

  logic reg_sel;
  logic wr_en;

  // register index is the word address
  assign reg_sel = (paddr[2] == dfr_pkg::REG_START_BYTE);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= 8'd0;
    end else if (wr_en) begin
      start_byte <= pwdata[7:0];
    end
  end

  // read back
  always_comb begin
    prdata = 32'd0;
    if (reg_sel) begin
      prdata = {24'd0, start_byte};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dfr_parse.sv =====
// framing state machine, length counter and checksum accumulator
`default_nettype none

module dfr_parse (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [7:0]   start_byte,
  input  wire logic         take,
  input  wire logic [7:0]   rx_byte,
  output logic              res_valid,
  output dfr_pkg::res_t     res
);

  dfr_pkg::phase_t phase, phase_next;
  logic [7:0]  meta_reg, meta_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [15:0] sum_acc, sum_acc_next;
  logic [7:0]  check_low, check_low_next;
  logic [15:0] left_dec;
  logic [15:0] len_full;
  logic [15:0] got_sum;

  assign left_dec = bytes_left - 16'd1;
  assign len_full = {rx_byte, length_reg[7:0]};
  assign got_sum  = {rx_byte, check_low};

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      dfr_pkg::PH_META:    phase_next = dfr_pkg::PH_LEN_LO;
      dfr_pkg::PH_LEN_LO:  phase_next = dfr_pkg::PH_LEN_HI;
      dfr_pkg::PH_LEN_HI:  phase_next = (len_full == 16'd0) ? dfr_pkg::PH_CHK_LO
                                                            : dfr_pkg::PH_PAYLOAD;
      dfr_pkg::PH_PAYLOAD: phase_next = (left_dec == 16'd0) ? dfr_pkg::PH_CHK_LO
                                                            : dfr_pkg::PH_PAYLOAD;
      dfr_pkg::PH_CHK_LO:  phase_next = dfr_pkg::PH_CHK_HI;
      dfr_pkg::PH_CHK_HI:  phase_next = dfr_pkg::PH_HUNT;
      default:             phase_next = (rx_byte == start_byte) ? dfr_pkg::PH_META
                                                                : dfr_pkg::PH_HUNT;
    endcase
  end

  // header fields, counter and running sum
  always_comb begin
    meta_reg_next   = meta_reg;
    length_reg_next = length_reg;
    bytes_left_next = bytes_left;
    sum_acc_next    = sum_acc;
    check_low_next  = check_low;
    case (phase)
      dfr_pkg::PH_META: begin
        meta_reg_next = rx_byte;
      end
      dfr_pkg::PH_LEN_LO: begin
        length_reg_next = {8'd0, rx_byte};
      end
      dfr_pkg::PH_LEN_HI: begin
        length_reg_next = len_full;
        bytes_left_next = len_full;
        sum_acc_next    = {8'd0, meta_reg} + len_full;
      end
      dfr_pkg::PH_PAYLOAD: begin
        sum_acc_next    = sum_acc + {8'd0, rx_byte};
        bytes_left_next = left_dec;
      end
      dfr_pkg::PH_CHK_LO: begin
        check_low_next = rx_byte;
      end
      default: begin
      end
    endcase
  end

  // result word for this byte
  always_comb begin
    res_valid         = 1'b0;
    res.kind          = dfr_pkg::KIND_DATA;
    res.payload_byte  = 8'd0;
    res.meta_byte     = meta_reg;
    res.packet_length = length_reg;
    res.last          = 1'b0;
    case (phase)
      dfr_pkg::PH_PAYLOAD: begin
        res_valid        = 1'b1;
        res.payload_byte = rx_byte;
      end
      dfr_pkg::PH_CHK_HI: begin
        res_valid = 1'b1;
        res.kind  = (got_sum == (sum_acc ^ dfr_pkg::CHECK_INVERT)) ? dfr_pkg::KIND_GOOD
                                                                   : dfr_pkg::KIND_BAD;
        res.last  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= dfr_pkg::PH_HUNT;
      meta_reg   <= 8'd0;
      length_reg <= 16'd0;
      bytes_left <= 16'd0;
      sum_acc    <= 16'd0;
      check_low  <= 8'd0;
    end else if (take) begin
      phase      <= phase_next;
      meta_reg   <= meta_reg_next;
      length_reg <= length_reg_next;
      bytes_left <= bytes_left_next;
      sum_acc    <= sum_acc_next;
      check_low  <= check_low_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dfr_obuf.sv =====
// result output register, refilled in the cycle it drains
`default_nettype none

module dfr_obuf (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire dfr_pkg::res_t res_in,
  output logic               space,
  output logic               out_valid,
  input  wire logic          out_ready,
  output dfr_pkg::res_t      res_out
);

  logic out_valid_next;

  // room when empty or the held word leaves now
  assign space = !out_valid || out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/checksummed_packet_deframer_unit_tb.sv =====
// testbench for the checksummed packet deframer: random framed link traffic, scored on the fly
`timescale 1ns / 1ps

module checksummed_packet_deframer_unit_tb;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int PRINT_LIMIT = 40;
  localparam logic [dfr_pkg::APB_ADDR_W-1:0] START_BYTE_ADDR =
    dfr_pkg::APB_ADDR_W'(int'(dfr_pkg::REG_START_BYTE) * 4);

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [dfr_pkg::APB_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dfr_byte_if   link_if();
  dfr_result_if result_if();

  checksummed_packet_deframer_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .link    (link_if),
    .result  (result_if)
  );

  // link bytes waiting to be sent, and deframed words still owed by the block
  logic [7:0]    link_bytes_q[$];
  logic [7:0]    body_bytes[$];
  dfr_pkg::res_t expected_deframed[$];

  // shadow of the parser state and the start byte register
  dfr_pkg::phase_t parse_phase     = dfr_pkg::PH_HUNT;
  logic [7:0]      start_val       = 8'h00;
  logic [7:0]      hdr_meta        = 8'h00;
  logic [15:0]     hdr_length      = 16'h0000;
  logic [15:0]     bytes_remaining = 16'h0000;
  logic [15:0]     running_sum     = 16'h0000;
  logic [7:0]      check_lo        = 8'h00;

  int          error_count = 0;
  int          word_count  = 0;
  int unsigned cycle_count = 0;

  // sender burst state and receiver stall pattern
  int          burst_left = 1;
  int          gap_left   = 0;
  logic [15:0] ready_bits = 16'hFFFF;
  int          ready_age  = 0;

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_LIMIT) begin
      $display("[%0t] deframer mismatch: %s", $realtime, what);
    end
    error_count++;
  endtask

  // advance the shadow parser by one accepted link byte
  function automatic void deframe_link_byte(input logic [7:0] b);
    dfr_pkg::res_t w;
    case (parse_phase)
      dfr_pkg::PH_META: begin
        hdr_meta    = b;
        parse_phase = dfr_pkg::PH_LEN_LO;
      end
      dfr_pkg::PH_LEN_LO: begin
        hdr_length  = {8'h00, b};
        parse_phase = dfr_pkg::PH_LEN_HI;
      end
      dfr_pkg::PH_LEN_HI: begin
        hdr_length      = {b, hdr_length[7:0]};
        bytes_remaining = hdr_length;
        running_sum     = {8'h00, hdr_meta} + hdr_length;
        parse_phase     = (hdr_length == 16'h0000) ? dfr_pkg::PH_CHK_LO
                                                   : dfr_pkg::PH_PAYLOAD;
      end
      dfr_pkg::PH_PAYLOAD: begin
        running_sum     = running_sum + {8'h00, b};
        bytes_remaining = bytes_remaining - 16'd1;
        if (bytes_remaining == 16'h0000) begin
          parse_phase = dfr_pkg::PH_CHK_LO;
        end
        w.kind          = dfr_pkg::KIND_DATA;
        w.payload_byte  = b;
        w.meta_byte     = hdr_meta;
        w.packet_length = hdr_length;
        w.last          = 1'b0;
        expected_deframed.push_back(w);
      end
      dfr_pkg::PH_CHK_LO: begin
        check_lo    = b;
        parse_phase = dfr_pkg::PH_CHK_HI;
      end
      dfr_pkg::PH_CHK_HI: begin
        w.kind          = ({b, check_lo} == (running_sum ^ dfr_pkg::CHECK_INVERT))
                          ? dfr_pkg::KIND_GOOD : dfr_pkg::KIND_BAD;
        w.payload_byte  = 8'h00;
        w.meta_byte     = hdr_meta;
        w.packet_length = hdr_length;
        w.last          = 1'b1;
        expected_deframed.push_back(w);
        parse_phase = dfr_pkg::PH_HUNT;
      end
      default: begin
        parse_phase = (b == start_val) ? dfr_pkg::PH_META : dfr_pkg::PH_HUNT;
      end
    endcase
  endfunction

  // frame the body bytes with header and checksum, optionally spoiling the checksum
  function automatic void queue_frame(input logic [7:0] meta, input bit corrupt);
    logic [15:0] len;
    logic [15:0] sum;
    len = 16'(body_bytes.size());
    sum = {8'h00, meta} + len;
    foreach (body_bytes[i]) sum = sum + {8'h00, body_bytes[i]};
    sum = ~sum;
    if (corrupt) begin
      sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
    end
    link_bytes_q.push_back(start_val);
    link_bytes_q.push_back(meta);
    link_bytes_q.push_back(len[7:0]);
    link_bytes_q.push_back(len[15:8]);
    foreach (body_bytes[i]) link_bytes_q.push_back(body_bytes[i]);
    link_bytes_q.push_back(sum[7:0]);
    link_bytes_q.push_back(sum[15:8]);
  endfunction

  // mostly well-formed frames, some line noise and cut-short frames
  task automatic queue_random_traffic(input int item_goal);
    int         added;
    int         pick;
    int         n;
    int         len;
    logic [7:0] b;
    added = 0;
    while (added < item_goal) begin
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        // noise between frames, skipped while hunting
        n = $urandom_range(1, 4);
        repeat (n) begin
          b = 8'($urandom);
          if (b == start_val) b = ~b;
          link_bytes_q.push_back(b);
        end
      end else if (pick < 5) begin
        // header with a body that stops early; later bytes fill the frame
        len = $urandom_range(0, 12);
        n   = $urandom_range(0, len);
        link_bytes_q.push_back(start_val);
        link_bytes_q.push_back(8'($urandom));
        link_bytes_q.push_back(8'(len));
        link_bytes_q.push_back(8'h00);
        repeat (n) link_bytes_q.push_back(8'($urandom));
        added += 4 + n;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 13) len = $urandom_range(0, 8);
        else if (pick < 19) len = $urandom_range(9, 40);
        else len = $urandom_range(41, 300);
        body_bytes.delete();
        repeat (len) body_bytes.push_back(8'($urandom));
        queue_frame(8'($urandom), $urandom_range(0, 3) == 0);
        added += len + 6;
      end
    end
  endtask

  // write start_byte over apb, read it back, then update the shadow copy
  task automatic write_start_byte(input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= START_BYTE_ADDR;
    pwdata  <= {24'h000000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'h000000, value}) begin
      report_mismatch($sformatf("start_byte read %h, wrote %h", prdata, value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    start_val = value;
  endtask

  // let the link and result channels drain, then a few quiet cycles
  task automatic wait_drained();
    while (link_bytes_q.size() != 0 || link_if.valid || expected_deframed.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // link driver: bursts of words with random gaps, prediction on acceptance
  always @(posedge clk) begin
    if (rst) begin
      link_if.valid <= 1'b0;
    end else begin
      if (link_if.valid && link_if.ready) begin
        deframe_link_byte(link_if.rx_byte);
      end
      if (!link_if.valid || link_if.ready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          link_if.valid <= 1'b0;
        end else if (link_bytes_q.size() != 0) begin
          link_if.valid   <= 1'b1;
          link_if.rx_byte <= link_bytes_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          link_if.valid <= 1'b0;
        end
      end
    end
  end

  // result back-pressure: a rotating stall pattern, reloaded now and then
  always @(posedge clk) begin
    if (ready_age == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_bits <= 16'hFFFF;
        1:       ready_bits <= 16'($urandom);
        2:       ready_bits <= 16'($urandom) | 16'($urandom);
        default: ready_bits <= 16'($urandom) & 16'($urandom);
      endcase
      ready_age <= $urandom_range(16, 96);
    end else begin
      ready_bits <= {ready_bits[0], ready_bits[15:1]};
      ready_age  <= ready_age - 1;
    end
    result_if.ready <= ready_bits[0];
  end

  // result monitor: compare each taken word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_deframed.size() == 0) begin
        report_mismatch($sformatf("word %0d with nothing pending, kind %0d",
                                  word_count, result_if.kind));
      end else begin
        dfr_pkg::res_t w;
        w = expected_deframed.pop_front();
        if (result_if.kind !== w.kind)
          report_mismatch($sformatf("word %0d kind %0d, want %0d",
                                    word_count, result_if.kind, w.kind));
        if (result_if.payload_byte !== w.payload_byte)
          report_mismatch($sformatf("word %0d payload_byte %h, want %h",
                                    word_count, result_if.payload_byte, w.payload_byte));
        if (result_if.meta_byte !== w.meta_byte)
          report_mismatch($sformatf("word %0d meta_byte %h, want %h",
                                    word_count, result_if.meta_byte, w.meta_byte));
        if (result_if.packet_length !== w.packet_length)
          report_mismatch($sformatf("word %0d packet_length %0d, want %0d",
                                    word_count, result_if.packet_length, w.packet_length));
        if (result_if.last !== w.last)
          report_mismatch($sformatf("word %0d last %b, want %b",
                                    word_count, result_if.last, w.last));
      end
      word_count++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("checksummed_packet_deframer_unit_tb failed");
      $finish;
    end
  end

  // reset, directed frames, then random traffic under several start bytes
  initial begin
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    link_if.valid   = 1'b0;
    link_if.rx_byte = 8'h00;
    result_if.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_start_byte(8'h7E);

    // noise at both extremes while hunting
    link_bytes_q.push_back(8'h00);
    link_bytes_q.push_back(8'hFF);
    // zero-length frame, metadata at zero
    body_bytes.delete();
    queue_frame(8'h00, 1'b0);
    // start byte inside the body, extreme data and metadata
    body_bytes.delete();
    body_bytes.push_back(8'h7E);
    body_bytes.push_back(8'hFF);
    body_bytes.push_back(8'h00);
    queue_frame(8'hFF, 1'b0);
    // zero-length frame with a bad checksum
    body_bytes.delete();
    queue_frame(8'h5A, 1'b1);
    queue_random_traffic(150);
    wait_drained();

    write_start_byte(8'hFF);
    queue_random_traffic(150);
    wait_drained();

    write_start_byte(8'h00);
    queue_random_traffic(150);
    wait_drained();

    write_start_byte(8'($urandom));
    queue_random_traffic(150);
    wait_drained();

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("checksummed_packet_deframer_unit_tb passed");
    end else begin
      $display("checksummed_packet_deframer_unit_tb failed");
    end
    $finish;
  end

endmodule
